// File: rtl/udp_header_checksum_check_defines.svh
// ----------------------------------------------------------------------------
// UDP checksum check assertion macros
// Shared property forms for the checksum checker's assertions.
// ----------------------------------------------------------------------------
`ifndef UDP_HEADER_CHECKSUM_CHECK_DEFINES_SVH
`define UDP_HEADER_CHECKSUM_CHECK_DEFINES_SVH

// same-cycle implication, disabled in reset
`define UDPHCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define UDPHCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/udphcc_pkg.sv
// ----------------------------------------------------------------------------
// UDP checksum check package
// Types, constants and the ones-complement adder shared by the block.
// ----------------------------------------------------------------------------
package udphcc_pkg;

  localparam int unsigned COUNTER_WIDTH_DEF = 32;

  localparam logic [7:0]  UDP_PROTO = 8'd17;
  localparam logic [16:0] HDR_BYTES = 17'd8;
  localparam logic [16:0] INDEX_MAX = 17'h1FFFF;
  localparam logic [15:0] ONES_ALL  = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_OK         = 2'd0,
    KIND_NO_HEADER  = 2'd1,
    KIND_BAD_LENGTH = 2'd2,
    KIND_CHECKSUM   = 2'd3
  } error_kind_t;

  typedef struct packed {
    logic        checked;
    error_kind_t pre_kind;
    logic        need_csum;
    logic [15:0] sum;
    logic [15:0] pseudo;
  } verdict_t;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// File: rtl/udphcc_if.sv
// ----------------------------------------------------------------------------
// UDP checksum check channels
// Request channels for datagram bytes and for verdicts.
// ----------------------------------------------------------------------------
interface udphcc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [7:0]  ip_protocol;
  logic        already_dropped;

  modport source (
    output valid, data_byte, last_byte, source_address, dest_address, ip_protocol,
           already_dropped,
    input  ready
  );
  modport sink (
    input  valid, data_byte, last_byte, source_address, dest_address, ip_protocol,
           already_dropped,
    output ready
  );
endinterface

interface udphcc_out_if;
  logic        valid;
  logic        ready;
  logic        drop;
  logic [1:0]  error_kind;
  logic        was_checked;
  logic [31:0] error_total;

  modport source (
    output valid, drop, error_kind, was_checked, error_total,
    input  ready
  );
  modport sink (
    input  valid, drop, error_kind, was_checked, error_total,
    output ready
  );
endinterface

// File: rtl/udphcc_accum.sv
// ----------------------------------------------------------------------------
// UDP checksum check accumulator
// Registers each byte, tracks header fields and the running ones-complement
// sums, and hands a partial verdict on the last byte of a packet.
// ----------------------------------------------------------------------------
module udphcc_accum (
  input  logic                clk,
  input  logic                rst_n,
  udphcc_in_if.sink           in_chan,
  output udphcc_pkg::verdict_t vd,
  output logic                vd_valid,
  input  logic                vd_ready
);

  localparam logic [16:0] IDX_SRC_HI  = 17'd1;
  localparam logic [16:0] IDX_SRC_LO  = 17'd2;
  localparam logic [16:0] IDX_DST_HI  = 17'd3;
  localparam logic [16:0] IDX_DST_LO  = 17'd4;
  localparam logic [16:0] IDX_LEN_HI  = 17'd4;
  localparam logic [16:0] IDX_LEN_LO  = 17'd5;
  localparam logic [16:0] IDX_PROTO   = 17'd5;
  localparam logic [16:0] IDX_CSUM_HI = 17'd6;
  localparam logic [16:0] IDX_PLEN    = 17'd6;
  localparam logic [16:0] IDX_CSUM_LO = 17'd7;

  logic        a_valid_r;
  logic [7:0]  a_byte_r;
  logic        a_last_r;
  logic [31:0] a_src_r;
  logic [31:0] a_dst_r;
  logic [7:0]  a_proto_r;
  logic        a_drop_r;
  logic        a_adv;

  logic [16:0] idx_r, idx_nxt, idx_inc;
  logic [15:0] sum_r, sum_nxt, sum_add;
  logic [15:0] len_r, len_nxt;
  logic        csnz_r, csnz_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [15:0] pseudo_r, pseudo_nxt;
  logic [15:0] pseudo_word;
  logic [31:0] m_src_r, m_dst_r;
  logic [7:0]  m_proto_r;
  logic        m_drop_r;
  logic        eff_drop;
  logic [7:0]  eff_proto;

  udphcc_pkg::verdict_t vd_r, vd_nxt;
  logic                 vd_valid_r;

  assign a_adv         = a_valid_r && (!a_last_r || !vd_valid_r || vd_ready);
  assign in_chan.ready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      a_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      a_byte_r  <= in_chan.data_byte;
      a_last_r  <= in_chan.last_byte;
      a_src_r   <= in_chan.source_address;
      a_dst_r   <= in_chan.dest_address;
      a_proto_r <= in_chan.ip_protocol;
      a_drop_r  <= in_chan.already_dropped;
    end
  end

  always_comb begin
    eff_drop  = (idx_r == 17'd0) ? a_drop_r : m_drop_r;
    eff_proto = (idx_r == 17'd0) ? a_proto_r : m_proto_r;
    idx_inc   = (idx_r < udphcc_pkg::INDEX_MAX) ? idx_r + 17'd1 : idx_r;

    pend_nxt = (idx_r == IDX_LEN_HI) ? a_byte_r : pend_r;
    len_nxt  = (idx_r == IDX_LEN_LO) ? {pend_r, a_byte_r} : len_r;
    csnz_nxt = csnz_r ||
               (((idx_r == IDX_CSUM_HI) || (idx_r == IDX_CSUM_LO)) && (a_byte_r != 8'd0));

    sum_add = idx_r[0] ? {8'd0, a_byte_r} : {a_byte_r, 8'd0};
    if ((idx_r < 17'd6) || (idx_r < {1'b0, len_nxt})) begin
      sum_nxt = udphcc_pkg::ones_add(sum_r, sum_add);
    end else begin
      sum_nxt = sum_r;
    end

    case (idx_r)
      IDX_SRC_HI: pseudo_word = m_src_r[31:16];
      IDX_SRC_LO: pseudo_word = m_src_r[15:0];
      IDX_DST_HI: pseudo_word = m_dst_r[31:16];
      IDX_DST_LO: pseudo_word = m_dst_r[15:0];
      IDX_PROTO:  pseudo_word = {8'd0, udphcc_pkg::UDP_PROTO};
      IDX_PLEN:   pseudo_word = len_r;
      default:    pseudo_word = 16'd0;
    endcase
    pseudo_nxt = udphcc_pkg::ones_add(pseudo_r, pseudo_word);

    idx_nxt = idx_inc;

    vd_nxt.checked   = !eff_drop && (eff_proto == udphcc_pkg::UDP_PROTO);
    vd_nxt.need_csum = csnz_nxt;
    vd_nxt.sum       = sum_nxt;
    vd_nxt.pseudo    = pseudo_nxt;
    if (idx_inc < udphcc_pkg::HDR_BYTES) begin
      vd_nxt.pre_kind = udphcc_pkg::KIND_NO_HEADER;
    end else if (({1'b0, len_nxt} > idx_inc) ||
                 ({1'b0, len_nxt} < udphcc_pkg::HDR_BYTES)) begin
      vd_nxt.pre_kind = udphcc_pkg::KIND_BAD_LENGTH;
    end else begin
      vd_nxt.pre_kind = udphcc_pkg::KIND_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      sum_r     <= '0;
      len_r     <= '0;
      csnz_r    <= 1'b0;
      pend_r    <= '0;
      pseudo_r  <= '0;
      m_src_r   <= '0;
      m_dst_r   <= '0;
      m_proto_r <= '0;
      m_drop_r  <= 1'b0;
    end else if (a_adv) begin
      if (a_last_r) begin
        idx_r     <= '0;
        sum_r     <= '0;
        len_r     <= '0;
        csnz_r    <= 1'b0;
        pend_r    <= '0;
        pseudo_r  <= '0;
        m_src_r   <= '0;
        m_dst_r   <= '0;
        m_proto_r <= '0;
        m_drop_r  <= 1'b0;
      end else begin
        idx_r    <= idx_nxt;
        sum_r    <= sum_nxt;
        len_r    <= len_nxt;
        csnz_r   <= csnz_nxt;
        pend_r   <= pend_nxt;
        pseudo_r <= pseudo_nxt;
        if (idx_r == 17'd0) begin
          m_src_r   <= a_src_r;
          m_dst_r   <= a_dst_r;
          m_proto_r <= a_proto_r;
          m_drop_r  <= a_drop_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_valid_r <= 1'b0;
    end else begin
      vd_valid_r <= (vd_valid_r && !vd_ready) || (a_adv && a_last_r);
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_last_r) begin
      vd_r <= vd_nxt;
    end
  end

  assign vd       = vd_r;
  assign vd_valid = vd_valid_r;

endmodule

// File: rtl/udp_header_checksum_check.sv
// The verdict for a last byte passes the input, verdict and output registers.
// Throughput: one byte per cycle; the per-byte sum update is one 16-bit ones-add.
// Last bytes and verdict registers stall only when the result is held at the output.
// Reset (rst_n low, synchronous) clears per-packet state and the error count.
// ----------------------------------------------------------------------------
// UDP checksum check
// Verifies UDP length and checksum per datagram and counts failed packets.
// ----------------------------------------------------------------------------
`include "udp_header_checksum_check_defines.svh"

module udp_header_checksum_check #(
  parameter int unsigned COUNTER_WIDTH = udphcc_pkg::COUNTER_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  udphcc_in_if.sink    in_chan,
  udphcc_out_if.source out_chan
);

  udphcc_pkg::verdict_t    vd;
  logic                    vd_valid;
  logic                    vd_ready;
  logic                    v_adv;

  logic [15:0]             total;
  udphcc_pkg::error_kind_t kind_nxt;
  logic [COUNTER_WIDTH-1:0] err_cnt_r, err_cnt_nxt;
  logic [31:0]             clip;

  logic                    out_valid_r;
  logic                    drop_r;
  udphcc_pkg::error_kind_t kind_r;
  logic                    checked_r;
  logic [31:0]             total_r;

  udphcc_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .vd       (vd),
    .vd_valid (vd_valid),
    .vd_ready (vd_ready)
  );

  assign vd_ready = !out_valid_r || out_chan.ready;
  assign v_adv    = vd_valid && vd_ready;

  always_comb begin
    total = udphcc_pkg::ones_add(vd.sum, vd.pseudo);
    if (!vd.checked) begin
      kind_nxt = udphcc_pkg::KIND_OK;
    end else if (vd.pre_kind != udphcc_pkg::KIND_OK) begin
      kind_nxt = vd.pre_kind;
    end else if (vd.need_csum && (total != udphcc_pkg::ONES_ALL)) begin
      kind_nxt = udphcc_pkg::KIND_CHECKSUM;
    end else begin
      kind_nxt = udphcc_pkg::KIND_OK;
    end
    if ((kind_nxt != udphcc_pkg::KIND_OK) && (err_cnt_r != {COUNTER_WIDTH{1'b1}})) begin
      err_cnt_nxt = err_cnt_r + {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      err_cnt_nxt = err_cnt_r;
    end
  end

  generate
    if (COUNTER_WIDTH > 32) begin : g_clip_wide
      assign clip = (|err_cnt_nxt[COUNTER_WIDTH-1:32]) ? 32'hFFFF_FFFF : err_cnt_nxt[31:0];
    end else if (COUNTER_WIDTH == 32) begin : g_clip_full
      assign clip = err_cnt_nxt;
    end else begin : g_clip_narrow
      assign clip = {{(32-COUNTER_WIDTH){1'b0}}, err_cnt_nxt};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (v_adv) begin
        err_cnt_r <= err_cnt_nxt;
      end
      if (vd_ready) begin
        out_valid_r <= vd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v_adv) begin
      drop_r    <= (kind_nxt != udphcc_pkg::KIND_OK);
      kind_r    <= kind_nxt;
      checked_r <= vd.checked;
      total_r   <= clip;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.drop        = drop_r;
  assign out_chan.error_kind  = kind_r;
  assign out_chan.was_checked = checked_r;
  assign out_chan.error_total = total_r;

  `UDPHCC_ASSERT_NEXT(a_cnt_hold, !v_adv, $stable(err_cnt_r), "error count moved without a verdict")
  `UDPHCC_ASSERT_NEXT(a_cnt_mono, v_adv, err_cnt_r >= $past(err_cnt_r), "error count went down")
  `UDPHCC_ASSERT_NOW(a_drop_kind, out_valid_r,
    (drop_r == (kind_r != udphcc_pkg::KIND_OK)) && (checked_r || !drop_r),
    "drop disagrees with error kind")

endmodule
